// ----- rtl/core/binary_decision_tree_classifier_assert.svh -----
// Assertion macros shared by the classifier RTL
`ifndef BINARY_DECISION_TREE_CLASSIFIER_ASSERT_SVH
`define BINARY_DECISION_TREE_CLASSIFIER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define BDT_ASSERT_SAME(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define BDT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/bdt_pkg.sv -----
// Shared types and constants of the decision tree classifier
`timescale 1ns / 1ps

package bdt_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int PIXEL_COUNT = 784;

    localparam int NODE_AW = $clog2(NODE_COUNT);
    localparam int PIX_AW  = $clog2(PIXEL_COUNT);
    localparam int STEP_W  = $clog2(NODE_COUNT + 1);

    localparam logic [1:0] OP_WRITE_NODE  = 2'd0;
    localparam logic [1:0] OP_WRITE_PIXEL = 2'd1;
    localparam logic [1:0] OP_CLASSIFY    = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] node_index;
        logic       node_is_leaf;
        logic [9:0] node_feature;
        logic [3:0] node_class;
        logic [9:0] zero_child;
        logic       zero_child_present;
        logic [9:0] one_child;
        logic       one_child_present;
        logic [9:0] pixel_index;
        logic       pixel_value;
    } in_t;

    typedef struct packed {
        logic [3:0] predicted_class;
        logic       reached_leaf;
        logic       hit_step_limit;
    } out_t;

    // One entry of the node table, 37 bits
    typedef struct packed {
        logic       leaf;
        logic [9:0] feature;
        logic [3:0] cls;
        logic [9:0] zero_child;
        logic       zero_present;
        logic [9:0] one_child;
        logic       one_present;
    } node_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        node_t              wdata;
        logic               re;
        logic [NODE_AW-1:0] raddr;
    } node_port_t;

    typedef struct packed {
        logic              we;
        logic [PIX_AW-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [PIX_AW-1:0] raddr;
    } pix_port_t;

endpackage

// ----- rtl/core/bdt_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module bdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/bdt_walker.sv -----
// Input decode, tree walk sequencer and result register
`timescale 1ns / 1ps

module bdt_walker
    import bdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    output node_port_t node_port,
    input  node_t      node_rdata,
    output pix_port_t  pix_port,
    input  logic       pix_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NODE = 2'd1;
    localparam logic [1:0] ST_PIX  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NODE_COUNT);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    node_t             cur_node_reg, cur_node_next;
    logic              oob_reg, oob_next;
    out_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    logic       accept;
    logic       pix_bit;
    logic [9:0] child;
    logic       child_present;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Pick the child by the tested pixel; a feature past the image reads 0
    assign pix_bit       = !oob_reg && pix_rdata;
    assign child         = pix_bit ? cur_node_reg.one_child : cur_node_reg.zero_child;
    assign child_present = pix_bit ? cur_node_reg.one_present : cur_node_reg.zero_present;

    // Walk sequencer: node read, then pixel read, once per level
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cur_node_next  = cur_node_reg;
        oob_next       = oob_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        node_port.re   = 1'b0;
        node_port.raddr = '0;
        pix_port.re    = 1'b0;
        pix_port.raddr = '0;

        // Table and image writes, taken only while idle so they never meet a walk read
        node_port.we                 = accept && (in_data.operation == OP_WRITE_NODE)
                                       && (int'(in_data.node_index) < NODE_COUNT);
        node_port.waddr              = NODE_AW'(in_data.node_index);
        node_port.wdata.leaf         = in_data.node_is_leaf;
        node_port.wdata.feature      = in_data.node_feature;
        node_port.wdata.cls          = in_data.node_class;
        node_port.wdata.zero_child   = in_data.zero_child;
        node_port.wdata.zero_present = in_data.zero_child_present;
        node_port.wdata.one_child    = in_data.one_child;
        node_port.wdata.one_present  = in_data.one_child_present;

        pix_port.we    = accept && (in_data.operation == OP_WRITE_PIXEL)
                         && (int'(in_data.pixel_index) < PIXEL_COUNT);
        pix_port.waddr = PIX_AW'(in_data.pixel_index);
        pix_port.wdata = in_data.pixel_value;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Start at the root
                if (accept && (in_data.operation == OP_CLASSIFY))
                begin
                    node_port.re    = 1'b1;
                    node_port.raddr = '0;
                    step_next       = '0;
                    state_next      = ST_NODE;
                end
            end
            ST_NODE:
            begin
                cur_node_next = node_rdata;
                res_next      = '0;
                if (step_reg == STEP_LIMIT)
                begin
                    res_next.hit_step_limit = 1'b1;
                    state_next              = ST_DONE;
                end
                else if (node_rdata.leaf)
                begin
                    step_next                = step_reg + 1'b1;
                    res_next.predicted_class = node_rdata.cls;
                    res_next.reached_leaf    = 1'b1;
                    state_next               = ST_DONE;
                end
                else
                begin
                    step_next      = step_reg + 1'b1;
                    oob_next       = int'(node_rdata.feature) >= PIXEL_COUNT;
                    pix_port.re    = !oob_next;
                    pix_port.raddr = PIX_AW'(node_rdata.feature);
                    state_next     = ST_PIX;
                end
            end
            ST_PIX:
            begin
                // Absent or out-of-table child ends the walk as unknown
                if (!child_present || (int'(child) >= NODE_COUNT))
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    node_port.re    = 1'b1;
                    node_port.raddr = NODE_AW'(child);
                    state_next      = ST_NODE;
                end
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        cur_node_reg <= cur_node_next;
        oob_reg      <= oob_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/binary_decision_tree_classifier.sv -----
// Node and pixel write words are taken one per cycle while the block is idle.
// Classify: a node RAM read then a pixel RAM read per level, until a leaf is reached,
// a node has no usable child or the step limit stops the walk; the result then waits
// for the output register to free.
// No word is taken until the result has moved into the output register.
// Reset clears control and the output valid only; table and image must be written first.
`timescale 1ns / 1ps
`include "binary_decision_tree_classifier_assert.svh"

module binary_decision_tree_classifier
    import bdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    node_port_t node_port;
    node_t      node_rdata;
    logic [36:0] node_rdata_raw;
    pix_port_t  pix_port;
    logic [0:0] pix_rdata;

    assign node_rdata = node_t'(node_rdata_raw);

    // Sequencer
    bdt_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .node_port  (node_port),
        .node_rdata (node_rdata),
        .pix_port   (pix_port),
        .pix_rdata  (pix_rdata[0])
    );

    // Node table
    bdt_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_port.we),
        .waddr (node_port.waddr),
        .wdata (node_port.wdata),
        .re    (node_port.re),
        .raddr (node_port.raddr),
        .rdata (node_rdata_raw)
    );

    // Image bits
    bdt_ram #(
        .WIDTH (1),
        .DEPTH (PIXEL_COUNT)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_port.we),
        .waddr (pix_port.waddr),
        .wdata (pix_port.wdata),
        .re    (pix_port.re),
        .raddr (pix_port.raddr),
        .rdata (pix_rdata)
    );

    `BDT_ASSERT_SAME(a_node_rw_apart, clk, rst_n, node_port.re, !node_port.we,
        "node table read and write in the same cycle")

    `BDT_ASSERT_NEXT(a_busy_after_classify, clk, rst_n,
        in_valid && in_ready && (in_data.operation == OP_CLASSIFY), !in_ready,
        "block took a word right after a classify")

    `BDT_ASSERT_SAME(a_one_outcome, clk, rst_n, out_valid,
        !(out_data.reached_leaf && out_data.hit_step_limit),
        "result both reached a leaf and hit the step limit")

    `BDT_ASSERT_SAME(a_unknown_class_zero, clk, rst_n,
        out_valid && !out_data.reached_leaf, out_data.predicted_class == 4'd0,
        "result without a leaf carries a nonzero class")

endmodule
